@@ hdl/imu_serial_frame_decoder_defines.svh @@
// assertion macros for the imu serial frame decoder
// no dependencies; define SYNTH to compile the checks away
`ifndef IMU_SERIAL_FRAME_DECODER_DEFINES_SVH
`define IMU_SERIAL_FRAME_DECODER_DEFINES_SVH

`ifndef SYNTH
`define ISFD_ASSERT_IMPLY(label, clk, rst_n, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |-> (post)) \
		else $error(msg);
`define ISFD_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |=> (post)) \
		else $error(msg);
`else
`define ISFD_ASSERT_IMPLY(label, clk, rst_n, pre, post, msg)
`define ISFD_ASSERT_NEXT(label, clk, rst_n, pre, post, msg)
`endif

`endif

@@ hdl/isfd_pkg.sv @@
// shared types and constants of the imu serial frame decoder
// no dependencies
`default_nettype none

package isfd_pkg;

	localparam int unsigned FRAME_LEN           = 20;
	localparam int unsigned COUNT_LIMIT_DEFAULT = 255;
	// cells hold every frame byte but the last one, which is the incoming byte
	localparam int unsigned CHAIN_DEPTH         = FRAME_LEN - 1;

	localparam logic [7:0] START_MARK = 8'h24;
	localparam logic [7:0] TERM_CR    = 8'h0D;
	localparam logic [7:0] TERM_LF    = 8'h0A;
	localparam logic [7:0] TERM_NUL   = 8'h00;

	typedef logic [7:0] byte_t;

	typedef struct packed {
		logic shift;
		logic clear;
	} cell_ctrl_t;

endpackage

`default_nettype wire

@@ hdl/imu_serial_frame_decoder.sv @@
// Serial IMU frame decoder.
// Input channel (in_valid/in_ready, rx_byte) takes one received byte per request.
// A frame ends on the byte sequence 0x00, CR, LF; the history before the first
// byte of a frame counts as zero, so CR, LF alone also ends a (short) frame.
// At every frame end one result goes out on the output channel
// (out_valid/out_ready): frame_ok, frame_length (saturating at 255) and, for a
// good frame of exactly 20 bytes starting with '$', the message and packet
// counts and seven signed big-endian words; for any other frame those are 0.
// Bytes move through a chain of 19 byte cells, one shift per accepted byte;
// the result is decoded combinationally from the cells and the incoming byte.
// Throughput: one byte per cycle unless a pending result stalls the input. The result
// is registered, valid the cycle after the terminating LF is accepted. A single output
// register parts the channels: while a result waits, in_ready stays high only in a
// cycle where out_ready is high, so a stalled receiver stalls the input once a result is pending.
// Reset (arst_n low) empties the cells, the byte count and the output register.
// The byte count saturates at COUNT_LIMIT; an overlong frame is never good.
// Depends on isfd_pkg, isfd_cell and imu_serial_frame_decoder_defines.svh.
`default_nettype none

module imu_serial_frame_decoder #(
	parameter int unsigned COUNT_LIMIT = isfd_pkg::COUNT_LIMIT_DEFAULT
) (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                in_valid,
	output logic               in_ready,
	input  isfd_pkg::byte_t    rx_byte,
	output logic               out_valid,
	input  wire                out_ready,
	output logic               frame_ok,
	output logic [7:0]         frame_length,
	output logic [7:0]         message_count,
	output logic [7:0]         pkt_count,
	output logic signed [15:0] quat_w,
	output logic signed [15:0] quat_x,
	output logic signed [15:0] quat_y,
	output logic signed [15:0] quat_z,
	output logic signed [15:0] accel_x,
	output logic signed [15:0] accel_y,
	output logic signed [15:0] accel_z
);
	import isfd_pkg::*;

	`include "imu_serial_frame_decoder_defines.svh"

	localparam int unsigned CNT_W = $clog2(COUNT_LIMIT + 1);
	localparam int unsigned LEN_W = (CNT_W > 8) ? CNT_W : 8;
	localparam int unsigned LAST  = CHAIN_DEPTH - 1;

	byte_t      cell_data  [CHAIN_DEPTH];
	logic       cell_valid [CHAIN_DEPTH];
	cell_ctrl_t cell_ctrl;

	logic             accept;
	logic             frame_end;
	logic             good;
	logic             at_limit;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] count_after;
	logic [LEN_W-1:0] len_ext;
	logic             overflow_q;

	assign in_ready = !out_valid || out_ready;
	assign accept   = in_valid && in_ready;

	// history: cell 0 is the byte before rx_byte, cell 1 the one before that
	assign frame_end = (rx_byte == TERM_LF) && (cell_data[0] == TERM_CR)
		&& (cell_data[1] == TERM_NUL);

	assign cell_ctrl.shift = accept;
	assign cell_ctrl.clear = accept && frame_end;

	genvar gi;
	generate
		for (gi = 0; gi < CHAIN_DEPTH; gi++) begin : g_chain
			if (gi == 0) begin : g_head
				isfd_cell u_cell (
					.clk        (clk),
					.arst_n     (arst_n),
					.ctrl       (cell_ctrl),
					.prev_data  (rx_byte),
					.prev_valid (1'b1),
					.data       (cell_data[gi]),
					.valid      (cell_valid[gi])
				);
			end else begin : g_body
				isfd_cell u_cell (
					.clk        (clk),
					.arst_n     (arst_n),
					.ctrl       (cell_ctrl),
					.prev_data  (cell_data[gi-1]),
					.prev_valid (cell_valid[gi-1]),
					.data       (cell_data[gi]),
					.valid      (cell_valid[gi])
				);
			end
		end
	endgenerate

	assign at_limit    = (count_q == CNT_W'(COUNT_LIMIT));
	assign count_after = at_limit ? count_q : count_q + CNT_W'(1);
	assign len_ext     = LEN_W'(count_after);

	// exactly FRAME_LEN bytes means every cell holds a byte of this frame,
	// so frame byte k sits in cell LAST - k
	assign good = !overflow_q && !at_limit && cell_valid[LAST]
		&& (count_q == CNT_W'(FRAME_LEN - 1)) && (cell_data[LAST] == START_MARK);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			overflow_q <= 1'b0;
		end else if (accept) begin
			if (frame_end) begin
				count_q    <= '0;
				overflow_q <= 1'b0;
			end else begin
				count_q    <= count_after;
				overflow_q <= overflow_q || at_limit;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (accept && frame_end) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && frame_end) begin
			frame_ok      <= good;
			frame_length  <= (len_ext > LEN_W'(255)) ? 8'hFF : len_ext[7:0];
			message_count <= good ? cell_data[LAST-1] : '0;
			pkt_count     <= good ? cell_data[LAST-16] : '0;
			quat_w        <= good ? {cell_data[LAST-2], cell_data[LAST-3]} : '0;
			quat_x        <= good ? {cell_data[LAST-4], cell_data[LAST-5]} : '0;
			quat_y        <= good ? {cell_data[LAST-6], cell_data[LAST-7]} : '0;
			quat_z        <= good ? {cell_data[LAST-8], cell_data[LAST-9]} : '0;
			accel_x       <= good ? {cell_data[LAST-10], cell_data[LAST-11]} : '0;
			accel_y       <= good ? {cell_data[LAST-12], cell_data[LAST-13]} : '0;
			accel_z       <= good ? {cell_data[LAST-14], cell_data[LAST-15]} : '0;
		end
	end

	`ISFD_ASSERT_IMPLY(a_ok_len, clk, arst_n, out_valid && frame_ok, frame_length == 8'(FRAME_LEN), "good frame with wrong length")
	`ISFD_ASSERT_IMPLY(a_bad_zero, clk, arst_n, out_valid && !frame_ok, message_count == 8'd0 && quat_w == 16'sd0 && accel_z == 16'sd0, "bad frame carries payload")
	`ISFD_ASSERT_NEXT(a_end_clears, clk, arst_n, accept && frame_end, count_q == '0 && !overflow_q && !cell_valid[0], "frame state not cleared after frame end")
	`ISFD_ASSERT_IMPLY(a_ovf_sat, clk, arst_n, overflow_q, at_limit, "overflow set below count limit")

endmodule

`default_nettype wire

@@ hdl/isfd_cell.sv @@
// one byte cell of the frame shift chain: data plus a valid mark
// depends on isfd_pkg
`default_nettype none

module isfd_cell (
	input  wire                clk,
	input  wire                arst_n,
	input  isfd_pkg::cell_ctrl_t ctrl,
	input  isfd_pkg::byte_t    prev_data,
	input  wire                prev_valid,
	output isfd_pkg::byte_t    data,
	output logic               valid
);
	import isfd_pkg::*;

	byte_t data_q;
	logic  valid_q;

	always_ff @(posedge clk) begin
		if (ctrl.shift) begin
			data_q <= prev_data;
		end
	end

	// clear wins over shift: the frame that just ended leaves nothing behind
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctrl.clear) begin
			valid_q <= 1'b0;
		end else if (ctrl.shift) begin
			valid_q <= prev_valid;
		end
	end

	// an empty cell reads as zero, as the cleared history does
	assign data  = valid_q ? data_q : '0;
	assign valid = valid_q;

endmodule

`default_nettype wire

@@ tb/imu_serial_frame_decoder_tb.sv @@
// testbench for imu_serial_frame_decoder: byte streams in, decoded frame reports checked
// against an in-bench frame predictor; depends on isfd_pkg and the decoder rtl
`timescale 1ns / 100ps

module imu_serial_frame_decoder_tb;

	import isfd_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int HOLD_CYCLES = 400;
	localparam int SAT_LIMIT   = COUNT_LIMIT_DEFAULT;

	typedef struct packed {
		logic        frame_ok;
		logic [7:0]  frame_length;
		logic [7:0]  message_count;
		logic [7:0]  pkt_count;
		logic [15:0] quat_w;
		logic [15:0] quat_x;
		logic [15:0] quat_y;
		logic [15:0] quat_z;
		logic [15:0] accel_x;
		logic [15:0] accel_y;
		logic [15:0] accel_z;
	} frame_report_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	byte_t              rx_byte = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic               frame_ok;
	logic [7:0]         frame_length;
	logic [7:0]         message_count;
	logic [7:0]         pkt_count;
	logic signed [15:0] quat_w;
	logic signed [15:0] quat_x;
	logic signed [15:0] quat_y;
	logic signed [15:0] quat_z;
	logic signed [15:0] accel_x;
	logic signed [15:0] accel_y;
	logic signed [15:0] accel_z;

	imu_serial_frame_decoder uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.rx_byte      (rx_byte),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.frame_ok     (frame_ok),
		.frame_length (frame_length),
		.message_count(message_count),
		.pkt_count    (pkt_count),
		.quat_w       (quat_w),
		.quat_x       (quat_x),
		.quat_y       (quat_y),
		.quat_z       (quat_z),
		.accel_x      (accel_x),
		.accel_y      (accel_y),
		.accel_z      (accel_z)
	);

	// predictor state
	byte_t stream_hist [3];
	int    frame_bytes_seen;
	bit    count_overflow;
	byte_t first_byte;
	byte_t body_bytes [16];

	frame_report_t pending_reports [$];
	int            mismatches = 0;
	int            cycle_count = 0;
	int            send_idle_pct = 0;
	int            recv_stall_pct = 0;
	int            hold_seq = 0;
	int            hold_seen = 0;
	int            hold_left = 0;

	always #6 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// receiver: random stalls, plus a long hold-off on request
	always @(posedge clk) begin
		if (hold_seq != hold_seen) begin
			hold_seen <= hold_seq;
			hold_left <= HOLD_CYCLES;
			out_ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	function automatic bit decode_rx_byte(input byte_t b, output frame_report_t rep);
		bit good;
		rep = '0;
		if (frame_bytes_seen == 0)
			first_byte = b;
		else if (frame_bytes_seen <= 16)
			body_bytes[frame_bytes_seen - 1] = b;
		if (frame_bytes_seen < SAT_LIMIT)
			frame_bytes_seen++;
		else
			count_overflow = 1'b1;
		stream_hist[2] = stream_hist[1];
		stream_hist[1] = stream_hist[0];
		stream_hist[0] = b;
		if (!(stream_hist[0] == TERM_LF && stream_hist[1] == TERM_CR &&
				stream_hist[2] == TERM_NUL))
			return 1'b0;
		good = !count_overflow && frame_bytes_seen == FRAME_LEN && first_byte == START_MARK;
		rep.frame_ok = good;
		rep.frame_length = (frame_bytes_seen > 255) ? 8'd255 : 8'(frame_bytes_seen);
		if (good) begin
			rep.message_count = body_bytes[0];
			rep.pkt_count     = body_bytes[15];
			rep.quat_w  = {body_bytes[1], body_bytes[2]};
			rep.quat_x  = {body_bytes[3], body_bytes[4]};
			rep.quat_y  = {body_bytes[5], body_bytes[6]};
			rep.quat_z  = {body_bytes[7], body_bytes[8]};
			rep.accel_x = {body_bytes[9], body_bytes[10]};
			rep.accel_y = {body_bytes[11], body_bytes[12]};
			rep.accel_z = {body_bytes[13], body_bytes[14]};
		end
		stream_hist = '{default: '0};
		frame_bytes_seen = 0;
		count_overflow = 1'b0;
		return 1'b1;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("mismatch at cycle %0d: %s", cycle_count, msg);
		mismatches++;
	endtask

	task automatic check_field(input string name, input logic [15:0] got,
			input logic [15:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got %h expected %h", name, got, want));
	endtask

	// outputs are stable at the falling edge; a request seen here is taken at the next rise
	always @(negedge clk) begin
		frame_report_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_reports.size() == 0) begin
				report_mismatch("frame report with no frame pending");
			end else begin
				want = pending_reports.pop_front();
				check_field("frame_ok", 16'(frame_ok), 16'(want.frame_ok));
				check_field("frame_length", 16'(frame_length), 16'(want.frame_length));
				check_field("message_count", 16'(message_count), 16'(want.message_count));
				check_field("pkt_count", 16'(pkt_count), 16'(want.pkt_count));
				check_field("quat_w", quat_w, want.quat_w);
				check_field("quat_x", quat_x, want.quat_x);
				check_field("quat_y", quat_y, want.quat_y);
				check_field("quat_z", quat_z, want.quat_z);
				check_field("accel_x", accel_x, want.accel_x);
				check_field("accel_y", accel_y, want.accel_y);
				check_field("accel_z", accel_z, want.accel_z);
			end
		end
	end

	task automatic send_byte(input byte_t b);
		frame_report_t rep;
		bit taken;
		taken = 1'b0;
		if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		in_valid <= 1'b1;
		rx_byte <= b;
		while (!taken) begin
			@(negedge clk);
			taken = in_ready;
			if (taken && decode_rx_byte(b, rep))
				pending_reports = {pending_reports, rep};
			@(posedge clk);
		end
	endtask

	task automatic send_frame(input byte_t bytes [$]);
		foreach (bytes[i])
			send_byte(bytes[i]);
	endtask

	function automatic byte_t no_lf_byte();
		byte_t b;
		b = byte_t'($urandom_range(255));
		return (b == TERM_LF) ? 8'h0B : b;
	endfunction

	task automatic test_good_frame_extremes();
		send_frame('{START_MARK, 8'h00, 8'h80, 8'h00, 8'h7F, 8'hFF, 8'h80, 8'h00, 8'h7F,
			8'hFF, 8'h80, 8'h00, 8'h7F, 8'hFF, 8'h80, 8'h00, 8'hFF,
			TERM_NUL, TERM_CR, TERM_LF});
		send_frame('{START_MARK, 8'hFF, 8'h7F, 8'hFF, 8'h80, 8'h00, 8'h7F, 8'hFF, 8'h80,
			8'h00, 8'h7F, 8'hFF, 8'h80, 8'h00, 8'h7F, 8'hFF, 8'h00,
			TERM_NUL, TERM_CR, TERM_LF});
		send_frame('{START_MARK, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
			8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h02,
			TERM_NUL, TERM_CR, TERM_LF});
	endtask

	task automatic test_special_frames();
		byte_t frame [$];
		// short terminator right after a frame end has cleared the history
		send_frame('{TERM_CR, TERM_LF});
		send_frame('{TERM_NUL, TERM_CR, TERM_LF});
		// lone lf and cr-cr-lf do not close a frame
		send_frame('{TERM_LF, TERM_CR, TERM_CR, TERM_LF, TERM_NUL, TERM_CR, TERM_LF});
		// right length, wrong start mark
		frame = '{8'h23};
		repeat (16) frame = {frame, 8'h55};
		frame = {frame, TERM_NUL};
		frame = {frame, TERM_CR};
		frame = {frame, TERM_LF};
		send_frame(frame);
		// one short and one long with the start mark
		frame[0] = START_MARK;
		frame.delete(1);
		send_frame(frame);
		frame.insert(1, 8'h11);
		frame.insert(1, 8'h22);
		send_frame(frame);
	endtask

	task automatic test_overlong_frames();
		int totals [1] = '{257};
		byte_t frame [$];
		foreach (totals[t]) begin
			frame = '{START_MARK};
			repeat (totals[t] - 4) frame = {frame, no_lf_byte()};
			frame = {frame, TERM_NUL};
			frame = {frame, TERM_CR};
			frame = {frame, TERM_LF};
			send_frame(frame);
		end
	endtask

	task automatic test_random_traffic(input int idle_pct, input int stall_pct,
			input int min_bytes);
		int bytes_sent;
		int kind;
		byte_t frame [$];
		bytes_sent = 0;
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		while (bytes_sent < min_bytes) begin
			kind = $urandom_range(99);
			frame = {};
			if (kind < 70) begin
				frame = {frame, START_MARK};
				repeat (16) frame = {frame, byte_t'($urandom_range(255))};
			end else if (kind < 82) begin
				frame = {frame, ($urandom_range(1) ? START_MARK : byte_t'($urandom_range(255)))};
				repeat ($urandom_range(0, 25)) frame = {frame, byte_t'($urandom_range(255))};
			end else if (kind < 90) begin
				repeat ($urandom_range(0, 3)) frame = {frame, byte_t'($urandom_range(255))};
			end else if (kind < 92) begin
				frame = {frame, START_MARK};
				repeat ($urandom_range(20, 40)) frame = {frame, no_lf_byte()};
			end else begin
				frame = {frame, byte_t'($urandom_range(255))};
				repeat (16) frame = {frame, byte_t'($urandom_range(255))};
			end
			if (kind >= 82 && kind < 90 && $urandom_range(1)) begin
				frame = {frame, TERM_CR};
			end else begin
				frame = {frame, TERM_NUL};
				frame = {frame, TERM_CR};
			end
			frame = {frame, TERM_LF};
			send_frame(frame);
			bytes_sent += frame.size();
		end
	endtask

	task automatic test_output_stall();
		byte_t frame [$];
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_seq <= hold_seq + 1;
		// the sender keeps offering while the receiver holds off
		repeat (4) begin
			frame = '{START_MARK};
			repeat (16) frame = {frame, byte_t'($urandom_range(255))};
			frame = {frame, TERM_NUL};
			frame = {frame, TERM_CR};
			frame = {frame, TERM_LF};
			send_frame(frame);
		end
	endtask

	initial begin
		stream_hist = '{default: '0};
		frame_bytes_seen = 0;
		count_overflow = 1'b0;
		first_byte = '0;
		body_bytes = '{default: '0};
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_good_frame_extremes();
		test_special_frames();
		test_overlong_frames();
		test_random_traffic(0, 0, 35);
		test_random_traffic(50, 0, 35);
		test_random_traffic(0, 50, 35);
		test_random_traffic(17, 17, 35);
		test_output_stall();
		test_random_traffic(17, 17, 20);

		in_valid <= 1'b0;
		while (pending_reports.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (mismatches == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

@@ files.f @@
+incdir+hdl
hdl/isfd_pkg.sv
hdl/isfd_cell.sv
hdl/imu_serial_frame_decoder.sv
tb/imu_serial_frame_decoder_tb.sv
